// ===== hw/rtl/double_ended_queue_core_macros.svh =====
// ---------------------------------------------------------------------------
// double-ended queue assertion macros
// shared property shorthands for the deque checker
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/deq_pkg.sv =====
// ---------------------------------------------------------------------------
// deq_pkg
// types, constants and ring helpers of the double-ended queue
// ---------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned STAT_W = 2;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_BACK  = 3'd0,
    FUNC_PUSH_FRONT = 3'd1,
    FUNC_POP_BACK   = 3'd2,
    FUNC_POP_FRONT  = 3'd3,
    FUNC_QUERY      = 3'd4
  } deq_func_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_POP_EMPTY = 2'd1,
    STATUS_PUSH_FULL = 2'd2
  } deq_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_HOLD
  } deq_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    word_t             push_value;
  } in_item_t;

  typedef struct packed {
    word_t             popped_value;
    logic [STAT_W-1:0] status;
    word_t             front_value;
    word_t             back_value;
    cnt_t              entry_count;
    logic              is_empty;
  } out_item_t;

  function automatic idx_t ring_next(idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
  endfunction

  function automatic idx_t ring_prev(idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : i - idx_t'(1);
  endfunction

endpackage

// ===== hw/rtl/double_ended_queue_core.sv =====
// ---------------------------------------------------------------------------
// double_ended_queue_core
// double-ended queue of signed 32-bit words in a 64-entry ring buffer
// ---------------------------------------------------------------------------
// Each input transaction carries one operation (push back, push front, pop
// back, pop front, or a query for codes 4 to 7) and yields exactly one output
// transaction with the popped word, a status, the front and back words, the
// count and an empty flag. Words live in a 64-entry ram; the front and back
// words are also kept in registers so a push or a query finishes with no ram
// read. A successful pop passes through the fetch state, where it waits for
// the registered ram read of the word that becomes the new front or back.
// Pushes on a full queue and pops on an empty queue change nothing and
// report their status. One finished result may wait in the output register
// while the block takes the next transaction; if that one finishes before
// the output is taken, the block holds it and stalls input. The ram needs
// no clearing after reset, so the block takes transactions as soon as
// reset is released.
// ---------------------------------------------------------------------------
module double_ended_queue_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  deq_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output deq_pkg::out_item_t  out_data_o
);
  import deq_pkg::*;

  // control state
  deq_state_e state_q, state_d;
  idx_t       head_q, head_d;
  idx_t       tail_q, tail_d;
  cnt_t       count_q, count_d;
  logic       out_valid_q, out_valid_d;

  // payload registers
  word_t             front_q, front_d;
  word_t             back_q, back_d;
  logic              pop_back_q, pop_back_d;
  word_t             pend_popped_q, pend_popped_d;
  logic [STAT_W-1:0] pend_status_q, pend_status_d;
  out_item_t         out_q, out_d;

  // effect of the incoming operation
  word_t             op_popped;
  logic [STAT_W-1:0] op_status;
  idx_t              op_head, op_tail, op_waddr, op_raddr;
  cnt_t              op_count;
  word_t             op_front, op_back;
  logic              op_we, op_fetch, op_pop_back;

  // handshake
  logic in_fire;
  logic out_free;
  logic load_out;

  // ram port
  logic  ram_we, ram_re;
  word_t ram_rdata;

  // result source
  word_t             res_popped, res_front, res_back;
  logic [STAT_W-1:0] res_status;
  cnt_t              res_count;

  // only idle takes a transaction; the output slot frees when empty or taken
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // decode the operation against the current ring state
  always_comb begin
    op_popped   = '0;
    op_status   = STATUS_OK;
    op_head     = head_q;
    op_tail     = tail_q;
    op_count    = count_q;
    op_front    = front_q;
    op_back     = back_q;
    op_we       = 1'b0;
    op_waddr    = tail_q;
    op_fetch    = 1'b0;
    op_raddr    = head_q;
    op_pop_back = 1'b0;
    case (in_data_i.func)
      FUNC_PUSH_BACK: begin
        if (count_q == cnt_t'(DEPTH)) begin
          op_status = STATUS_PUSH_FULL;
        end else begin
          // write at the tail, new word is the back (and front if empty)
          op_we    = 1'b1;
          op_waddr = tail_q;
          op_tail  = ring_next(tail_q);
          op_count = count_q + cnt_t'(1);
          op_back  = in_data_i.push_value;
          if (count_q == '0) begin
            op_front = in_data_i.push_value;
          end
        end
      end
      FUNC_PUSH_FRONT: begin
        if (count_q == cnt_t'(DEPTH)) begin
          op_status = STATUS_PUSH_FULL;
        end else begin
          // step the head back and write there
          op_we    = 1'b1;
          op_waddr = ring_prev(head_q);
          op_head  = ring_prev(head_q);
          op_count = count_q + cnt_t'(1);
          op_front = in_data_i.push_value;
          if (count_q == '0) begin
            op_back = in_data_i.push_value;
          end
        end
      end
      FUNC_POP_BACK: begin
        if (count_q == '0) begin
          op_status = STATUS_POP_EMPTY;
        end else begin
          // new back sits two below the old tail
          op_popped   = back_q;
          op_tail     = ring_prev(tail_q);
          op_count    = count_q - cnt_t'(1);
          op_fetch    = 1'b1;
          op_raddr    = ring_prev(ring_prev(tail_q));
          op_pop_back = 1'b1;
        end
      end
      FUNC_POP_FRONT: begin
        if (count_q == '0) begin
          op_status = STATUS_POP_EMPTY;
        end else begin
          // new front sits one above the old head
          op_popped = front_q;
          op_head   = ring_next(head_q);
          op_count  = count_q - cnt_t'(1);
          op_fetch  = 1'b1;
          op_raddr  = ring_next(head_q);
        end
      end
      default: begin
        // query: nothing changes
      end
    endcase
  end

  assign ram_we = in_fire && op_we;
  assign ram_re = in_fire && op_fetch;

  deq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_deq_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (op_waddr),
    .wdata_i (in_data_i.push_value),
    .re_i    (ram_re),
    .raddr_i (op_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (op_fetch) begin
            state_d = ST_FETCH;
          end else if (!out_free) begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_FETCH: begin
        state_d = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and result loading per state
  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    front_d       = front_q;
    back_d        = back_q;
    pop_back_d    = pop_back_q;
    pend_popped_d = pend_popped_q;
    pend_status_d = pend_status_q;
    load_out      = 1'b0;
    res_popped    = pend_popped_q;
    res_status    = pend_status_q;
    res_count     = count_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          head_d        = op_head;
          tail_d        = op_tail;
          count_d       = op_count;
          front_d       = op_front;
          back_d        = op_back;
          pop_back_d    = op_pop_back;
          pend_popped_d = op_popped;
          pend_status_d = op_status;
          load_out      = !op_fetch && out_free;
        end
        res_popped = op_popped;
        res_status = op_status;
        res_count  = op_count;
      end
      ST_FETCH: begin
        // ram data is the word at the end that just moved
        if (pop_back_q) begin
          back_d = ram_rdata;
        end else begin
          front_d = ram_rdata;
        end
        load_out = out_free;
      end
      ST_HOLD: begin
        load_out = out_free;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
    res_front = front_d;
    res_back  = back_d;
  end

  // output register, loaded only when its slot is free
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d          = 1'b1;
      out_d.popped_value   = res_popped;
      out_d.status         = res_status;
      out_d.front_value    = (res_count == '0) ? '0 : res_front;
      out_d.back_value     = (res_count == '0) ? '0 : res_back;
      out_d.entry_count    = res_count;
      out_d.is_empty       = (res_count == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q       <= front_d;
    back_q        <= back_d;
    pop_back_q    <= pop_back_d;
    pend_popped_q <= pend_popped_d;
    pend_status_q <= pend_status_d;
    out_q         <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/deq_ram.sv =====
// ---------------------------------------------------------------------------
// deq_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/deq_checker.sv =====
// ---------------------------------------------------------------------------
// deq_checker
// port-level checks of the double-ended queue, bound to the top level
// ---------------------------------------------------------------------------
`include "double_ended_queue_core_macros.svh"

module deq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input deq_pkg::out_item_t out_data_o
);
  import deq_pkg::*;

  // a stalled result stays put
  `DEQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled output transaction changed")

  // empty flag agrees with the count
  `DEQ_ASSERT_NOW(a_empty_flag, clk_i, rst_ni, out_valid_o, out_data_o.is_empty == (out_data_o.entry_count == '0), "empty flag disagrees with count")

  // count never exceeds the ring size
  `DEQ_ASSERT_NOW(a_count_bound, clk_i, rst_ni, out_valid_o, out_data_o.entry_count <= cnt_t'(DEPTH), "count beyond ring size")

  // an empty queue shows zero at both ends
  `DEQ_ASSERT_NOW(a_empty_ends, clk_i, rst_ni, out_valid_o && out_data_o.is_empty, (out_data_o.front_value == '0) && (out_data_o.back_value == '0), "empty queue shows nonzero end word")

  // a failed pop returns no word
  `DEQ_ASSERT_NOW(a_pop_empty_zero, clk_i, rst_ni, out_valid_o && (out_data_o.status == STATUS_POP_EMPTY), (out_data_o.popped_value == '0) && out_data_o.is_empty, "pop on empty queue returned a word")

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);
